// ===== rtl/mbgs_pkg.sv =====
// Shared constants for the masked bilinear grid sampler.
package mbgs_pkg;

  localparam int LON_W   = 25;
  localparam int LAT_W   = 24;
  localparam int VAL_W   = 32;
  localparam int ADDR_W  = 14;
  localparam int FRAC_W  = 16;
  localparam int SIZE_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LAT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LAT   = 3'd5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [LON_W-1:0] RST_MIN_LON = -25'sd11796480;
  localparam logic signed [LON_W-1:0] RST_MAX_LON = 25'sd11796480;
  localparam logic signed [LAT_W-1:0] RST_MIN_LAT = -24'sd5898240;
  localparam logic signed [LAT_W-1:0] RST_MAX_LAT = 24'sd5898240;

endpackage

// ===== rtl/masked_bilinear_grid_sampler.sv =====
// Masked bilinear grid sampler: cell store, coordinate divider and blend unit.
//
// Input words arrive on in_valid_i/in_ready_o. A write word (cmd 0) stores one
// cell and its valid bit in the accepting cycle and gives no output word. A
// query word (cmd 1) gives exactly one output word on out_valid_o/out_ready_i.
// The output word of a query is offered once these steps have run in order:
// the restoring divider that scales both axes retires one quotient bit a cycle,
// then the single read port of the cell memory fetches the four corners one per
// cycle, and the blend unit runs three multiply and round passes when the four
// corners are blended; when the nearest cell is used, its value is taken in place
// of the blend. The next input word is taken from the cycle after the output
// register is loaded. A write word leaves the block idle and ready for the next
// input word.
// After reset the block sweeps the cell memory once to clear every valid bit,
// one cell a cycle over all MAX_COLS*MAX_ROWS cells (16384 by default), and accepts no
// input word until then. Configuration writes are taken at any time.
// A finished output word sits in an output register; the block keeps working
// on the next query and holds its result until the output register is free.
module masked_bilinear_grid_sampler #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mbgs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mbgs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [mbgs_pkg::ADDR_W-1:0]        cell_addr_i,
  input  logic signed [mbgs_pkg::VAL_W-1:0]  cell_value_i,
  input  logic                               cell_valid_i,
  input  logic signed [mbgs_pkg::LON_W-1:0]  lon_i,
  input  logic signed [mbgs_pkg::LAT_W-1:0]  lat_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mbgs_pkg::VAL_W-1:0]  sample_value_o,
  output logic                               found_o
);
  import mbgs_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NWX   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NWY   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NW    = (NWX > NWY) ? NWX : NWY;
  localparam int QW    = NW + FRAC_W;
  localparam int DW    = LON_W;
  localparam int PW    = DW + NW;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int KW    = CW + RW;
  localparam int DCW   = $clog2(QW + 1);
  localparam int MW    = VAL_W + FRAC_W + 2;
  localparam int SW    = MW + 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_MUL, ST_DIV, ST_ADDR, ST_READ,
    ST_WAIT, ST_EVAL, ST_NEAR, ST_LMUL, ST_LADD, ST_OUT
  } state_e;

  state_e state_q;

  logic [SIZE_W-1:0]       grid_cols_q, grid_rows_q;
  logic signed [LON_W-1:0] min_lon_q, max_lon_q;
  logic signed [LAT_W-1:0] min_lat_q, max_lat_q;

  logic [VAL_W:0] mem [DEPTH];
  logic [VAL_W:0] rdata_q;
  logic [AW-1:0]  raddr, waddr;
  logic [VAL_W:0] wdata;
  logic           we;
  logic [AW-1:0]  clr_q;

  logic signed [LON_W-1:0] lon_q;
  logic signed [LAT_W-1:0] lat_q;
  logic [DW-1:0] dx_q, dy_q, spx_q, spy_q, remx_q, remy_q;
  logic          zx_q, zy_q;
  logic [QW-1:0] bitsx_q, bitsy_q, qx_q, qy_q;
  logic [DCW-1:0] dcnt_q;
  logic [AW-1:0] k_q [5];
  logic [FRAC_W-1:0] fu_q, fv_q;
  logic [1:0] rcnt_q, pidx_q, lcnt_q;
  logic       pend_q;
  logic [VAL_W:0] cv_q [4];
  logic signed [MW-1:0] p0_q, p1_q;
  logic signed [VAL_W-1:0] a_q, b_q, res_q;
  logic res_found_q;

  logic [CW-1:0] cols_c;
  logic [RW-1:0] rows_c;
  logic in_acc;

  always_comb begin
    if (grid_cols_q == '0) begin
      cols_c = CW'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_c = CW'(MAX_COLS);
    end else begin
      cols_c = CW'(grid_cols_q);
    end
    if (grid_rows_q == '0) begin
      rows_c = RW'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(grid_rows_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Clamp, span and offset for both axes.
  logic signed [LON_W-1:0] pcx;
  logic signed [LAT_W-1:0] pcy;
  logic signed [LON_W:0]   dxs, sxs, dys, sys;
  always_comb begin
    pcx = lon_q;
    if (pcx > max_lon_q) pcx = max_lon_q;
    if (pcx < min_lon_q) pcx = min_lon_q;
    pcy = lat_q;
    if (pcy > max_lat_q) pcy = max_lat_q;
    if (pcy < min_lat_q) pcy = min_lat_q;
    dxs = (LON_W+1)'(pcx) - (LON_W+1)'(min_lon_q);
    sxs = (LON_W+1)'(max_lon_q) - (LON_W+1)'(min_lon_q);
    dys = (LON_W+1)'(pcy) - (LON_W+1)'(min_lat_q);
    sys = (LON_W+1)'(max_lat_q) - (LON_W+1)'(min_lat_q);
  end

  logic [PW-1:0] prodx, prody;
  assign prodx = PW'(dx_q) * PW'(cols_c - CW'(1));
  assign prody = PW'(dy_q) * PW'(rows_c - RW'(1));

  logic [DW:0] tx, ty;
  assign tx = {remx_q, bitsx_q[QW-1]};
  assign ty = {remy_q, bitsy_q[QW-1]};

  // Grid indices of the corners and of the nearest cell.
  logic [QW-1:0] ux, uy;
  logic [QW:0]   unx, uny;
  logic [CW:0]   i0, i1, inn;
  logic [RW:0]   j0, j1, jn;
  always_comb begin
    ux  = zx_q ? '0 : qx_q;
    uy  = zy_q ? '0 : qy_q;
    i0  = (CW+1)'(ux >> FRAC_W);
    j0  = (RW+1)'(uy >> FRAC_W);
    i1  = (i0 + 1'b1 < (CW+1)'(cols_c)) ? i0 + 1'b1 : (CW+1)'(cols_c) - 1'b1;
    j1  = (j0 + 1'b1 < (RW+1)'(rows_c)) ? j0 + 1'b1 : (RW+1)'(rows_c) - 1'b1;
    unx = ((QW+1)'(ux) + (QW+1)'(32768)) >> FRAC_W;
    uny = ((QW+1)'(uy) + (QW+1)'(32768)) >> FRAC_W;
    inn = (unx > (QW+1)'(cols_c - CW'(1))) ? (CW+1)'(cols_c - CW'(1)) : (CW+1)'(unx);
    jn  = (uny > (QW+1)'(rows_c - RW'(1))) ? (RW+1)'(rows_c - RW'(1)) : (RW+1)'(uny);
  end

  function automatic logic [AW-1:0] flat_index(logic [RW:0] j, logic [CW:0] i,
                                               logic [CW-1:0] n);
    logic [KW:0] k;
    k = (KW+1)'(j) * (KW+1)'(n) + (KW+1)'(i);
    return AW'(k);
  endfunction

  // Blend unit operands.
  logic signed [VAL_W-1:0] op0, op1;
  logic [FRAC_W-1:0]       fr;
  logic [FRAC_W:0]         w0, w1;
  logic signed [SW-1:0]    bsum;
  always_comb begin
    unique case (lcnt_q)
      2'd0: begin
        op0 = cv_q[0][VAL_W-1:0];
        op1 = cv_q[1][VAL_W-1:0];
        fr  = fu_q;
      end
      2'd1: begin
        op0 = cv_q[2][VAL_W-1:0];
        op1 = cv_q[3][VAL_W-1:0];
        fr  = fu_q;
      end
      default: begin
        op0 = a_q;
        op1 = b_q;
        fr  = fv_q;
      end
    endcase
    w1   = (FRAC_W+1)'(fr);
    w0   = (FRAC_W+1)'(65536) - w1;
    bsum = SW'(p0_q) + SW'(p1_q) + SW'(32768);
  end

  // Memory port selection.
  always_comb begin
    raddr = (state_q == ST_READ) ? k_q[rcnt_q] : k_q[4];
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = in_acc && (cmd_i == CMD_WRITE) && (32'(cell_addr_i) < DEPTH);
      waddr = AW'(cell_addr_i);
      wdata = {cell_valid_i, cell_value_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      grid_cols_q <= SIZE_W'(128);
      grid_rows_q <= SIZE_W'(128);
      min_lon_q   <= RST_MIN_LON;
      max_lon_q   <= RST_MAX_LON;
      min_lat_q   <= RST_MIN_LAT;
      max_lat_q   <= RST_MAX_LAT;
      out_valid_o <= 1'b0;
      sample_value_o <= '0;
      found_o     <= 1'b0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      rcnt_q      <= '0;
      lcnt_q      <= '0;
      dcnt_q      <= '0;
      lon_q <= '0;  lat_q <= '0;
      dx_q <= '0;   dy_q <= '0;   spx_q <= '0;  spy_q <= '0;
      remx_q <= '0; remy_q <= '0; zx_q <= 1'b1; zy_q <= 1'b1;
      bitsx_q <= '0; bitsy_q <= '0; qx_q <= '0; qy_q <= '0;
      for (int n = 0; n < 5; n++) k_q[n] <= '0;
      for (int n = 0; n < 4; n++) cv_q[n] <= '0;
      fu_q <= '0; fv_q <= '0;
      p0_q <= '0; p1_q <= '0;
      a_q <= '0;  b_q <= '0; res_q <= '0; res_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GRID_COLS: grid_cols_q <= cfg_wdata_i[SIZE_W-1:0];
          REG_GRID_ROWS: grid_rows_q <= cfg_wdata_i[SIZE_W-1:0];
          REG_MIN_LON:   min_lon_q   <= cfg_wdata_i[LON_W-1:0];
          REG_MAX_LON:   max_lon_q   <= cfg_wdata_i[LON_W-1:0];
          REG_MIN_LAT:   min_lat_q   <= cfg_wdata_i[LAT_W-1:0];
          REG_MAX_LAT:   max_lat_q   <= cfg_wdata_i[LAT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_o && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end

      pend_q <= (state_q == ST_READ);
      if (pend_q) begin
        cv_q[pidx_q] <= rdata_q;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == DEPTH - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && (cmd_i == CMD_QUERY)) begin
            lon_q   <= lon_i;
            lat_q   <= lat_i;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          dx_q  <= dxs[DW-1:0];
          dy_q  <= dys[DW-1:0];
          spx_q <= sxs[DW-1:0];
          spy_q <= sys[DW-1:0];
          zx_q  <= (cols_c <= CW'(1)) || (max_lon_q <= min_lon_q);
          zy_q  <= (rows_c <= RW'(1)) || (max_lat_q <= min_lat_q);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          remx_q  <= DW'(prodx >> NW);
          remy_q  <= DW'(prody >> NW);
          bitsx_q <= {prodx[NW-1:0], FRAC_W'(0)};
          bitsy_q <= {prody[NW-1:0], FRAC_W'(0)};
          qx_q    <= '0;
          qy_q    <= '0;
          dcnt_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          bitsx_q <= bitsx_q << 1;
          bitsy_q <= bitsy_q << 1;
          if (tx >= {1'b0, spx_q}) begin
            remx_q <= DW'(tx - {1'b0, spx_q});
            qx_q   <= {qx_q[QW-2:0], 1'b1};
          end else begin
            remx_q <= DW'(tx);
            qx_q   <= {qx_q[QW-2:0], 1'b0};
          end
          if (ty >= {1'b0, spy_q}) begin
            remy_q <= DW'(ty - {1'b0, spy_q});
            qy_q   <= {qy_q[QW-2:0], 1'b1};
          end else begin
            remy_q <= DW'(ty);
            qy_q   <= {qy_q[QW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCW'(QW - 1)) begin
            state_q <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          k_q[0] <= flat_index(j0, i0, cols_c);
          k_q[1] <= flat_index(j0, i1, cols_c);
          k_q[2] <= flat_index(j1, i0, cols_c);
          k_q[3] <= flat_index(j1, i1, cols_c);
          k_q[4] <= flat_index(jn, inn, cols_c);
          fu_q   <= ux[FRAC_W-1:0];
          fv_q   <= uy[FRAC_W-1:0];
          rcnt_q <= '0;
          state_q <= ST_READ;
        end
        ST_READ: begin
          pidx_q <= rcnt_q;
          rcnt_q <= rcnt_q + 1'b1;
          if (rcnt_q == 2'd3) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          lcnt_q <= '0;
          if (cv_q[0][VAL_W] && cv_q[1][VAL_W] && cv_q[2][VAL_W] && cv_q[3][VAL_W]) begin
            state_q <= ST_LMUL;
          end else begin
            state_q <= ST_NEAR;
          end
        end
        ST_NEAR: begin
          res_found_q <= rdata_q[VAL_W];
          res_q   <= rdata_q[VAL_W] ? rdata_q[VAL_W-1:0] : '0;
          state_q <= ST_OUT;
        end
        ST_LMUL: begin
          p0_q <= MW'(op0) * MW'($signed({1'b0, w0}));
          p1_q <= MW'(op1) * MW'($signed({1'b0, w1}));
          state_q <= ST_LADD;
        end
        ST_LADD: begin
          lcnt_q <= lcnt_q + 1'b1;
          case (lcnt_q)
            2'd0: begin
              a_q <= bsum[VAL_W+FRAC_W-1:FRAC_W];
              state_q <= ST_LMUL;
            end
            2'd1: begin
              b_q <= bsum[VAL_W+FRAC_W-1:FRAC_W];
              state_q <= ST_LMUL;
            end
            default: begin
              res_q <= bsum[VAL_W+FRAC_W-1:FRAC_W];
              res_found_q <= 1'b1;
              state_q <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o    <= 1'b1;
            sample_value_o <= res_q;
            found_o        <= res_found_q;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
